### hw/rtl/rsnh_pkg.sv
// ----------------------------------------------------------------------------
// Ray-sphere nearest hit: shared package
// Types, codes and constants used by the front end, the back end and the
// top level of the nearest-hit engine.
// ----------------------------------------------------------------------------
package rsnh_pkg;

   // Default size of the sphere table.
   localparam int MAX_SPHERES_DEF = 16;

   // Distance reported when a ray meets nothing (1e12 as binary32).
   localparam logic [31:0] MISS_DISTANCE = 32'h5368D4A5;

   // Quiet NaN produced by invalid float operations.
   localparam logic [31:0] QNAN = 32'h7FC00000;

   // Input command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_RAY   = 1'b1;

   // Classification of an accepted beat.
   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_RAY,
      KIND_NOP
   } kind_type;

   // Float unit operations.
   typedef enum logic [1:0] {
      FP_ADD,
      FP_SUB,
      FP_MUL
   } fp_op_type;

   // Raw input beat as it arrives on the request ports.
   typedef struct packed {
      logic        cmd;
      logic [3:0]  slot;
      logic [31:0] center_x;
      logic [31:0] center_y;
      logic [31:0] center_z;
      logic [31:0] radius;
      logic [31:0] origin_x;
      logic [31:0] origin_y;
      logic [31:0] origin_z;
      logic [31:0] dir_x;
      logic [31:0] dir_y;
      logic [31:0] dir_z;
   } req_type;

   // Classified work item passed from the front end to the back end.
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  slot;
      logic [31:0] center_x;
      logic [31:0] center_y;
      logic [31:0] center_z;
      logic [31:0] radius;
      logic [31:0] origin_x;
      logic [31:0] origin_y;
      logic [31:0] origin_z;
      logic [31:0] dir_x;
      logic [31:0] dir_y;
      logic [31:0] dir_z;
   } item_type;

   // One result beat.
   typedef struct packed {
      logic        hit;
      logic [31:0] hit_distance;
      logic [3:0]  hit_slot;
   } rsp_type;

endpackage

### hw/rtl/rsnh_fpu.sv
// ----------------------------------------------------------------------------
// Ray-sphere nearest hit: binary32 add/subtract/multiply unit
// One operation per cycle, round to nearest even, full subnormal support.
// The result is registered and appears in the cycle after the operation.
// ----------------------------------------------------------------------------
module rsnh_fpu (
   input  logic                clock,
   input  rsnh_pkg::fp_op_type op,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   output logic [31:0]         res
);

   logic [31:0] res_ff;
   logic [31:0] res_in;

   // Normalize and round a significand. The value is sig / 2^48 * 2^(e - 127).
   function automatic logic [31:0] round_pack(input logic sign,
                                              input logic signed [11:0] e,
                                              input logic [49:0] sig);
      logic [5:0]         lz;
      logic               found;
      logic [49:0]        nrm;
      logic [49:0]        shf;
      logic signed [11:0] en;
      logic signed [11:0] ee;
      logic [11:0]        sh;
      logic [23:0]        mant;
      logic               g;
      logic               st;
      logic [24:0]        m25;
      logic [31:0]        r;
      lz    = '0;
      found = 1'b0;
      for (int i = 49; i >= 0; i--) begin
         if (!found && sig[i]) begin
            lz    = 6'(49 - i);
            found = 1'b1;
         end
      end
      nrm = sig << lz;
      en  = e + 12'sd1 - $signed({6'b0, lz});
      // Values below the normal range are shifted into subnormal position.
      if (en >= 12'sd1) begin
         shf = nrm;
         st  = 1'b0;
         ee  = en;
      end else begin
         sh = 12'(12'sd1 - en);
         if (sh >= 12'd50) begin
            shf = '0;
            st  = |nrm;
         end else begin
            shf = nrm >> sh;
            st  = |(nrm & ~({50{1'b1}} << sh));
         end
         ee = 12'sd1;
      end
      mant = shf[49:26];
      g    = shf[25];
      st   = st | (|shf[24:0]);
      m25  = {1'b0, mant} + 25'(g & (st | mant[0]));
      if (m25[24]) begin
         mant = m25[24:1];
         ee   = ee + 12'sd1;
      end else begin
         mant = m25[23:0];
      end
      if (sig == '0) begin
         r = {sign, 31'b0};
      end else if (ee >= 12'sd255) begin
         r = {sign, 8'hFF, 23'b0};
      end else begin
         r = {sign, (mant[23] ? ee[7:0] : 8'h00), mant[22:0]};
      end
      return r;
   endfunction

   // Product of two binary32 values.
   function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
      logic               s;
      logic               xnan;
      logic               ynan;
      logic               xinf;
      logic               yinf;
      logic               xz;
      logic               yz;
      logic [23:0]        mx;
      logic [23:0]        my;
      logic [47:0]        p;
      logic signed [11:0] ex;
      logic signed [11:0] ey;
      logic [31:0]        r;
      s    = x[31] ^ y[31];
      xnan = (x[30:23] == 8'hFF) && (x[22:0] != '0);
      ynan = (y[30:23] == 8'hFF) && (y[22:0] != '0);
      xinf = (x[30:23] == 8'hFF) && (x[22:0] == '0);
      yinf = (y[30:23] == 8'hFF) && (y[22:0] == '0);
      xz   = (x[30:0] == '0);
      yz   = (y[30:0] == '0);
      mx   = {x[30:23] != 8'h00, x[22:0]};
      my   = {y[30:23] != 8'h00, y[22:0]};
      ex   = (x[30:23] == 8'h00) ? 12'sd1 : $signed({4'b0, x[30:23]});
      ey   = (y[30:23] == 8'h00) ? 12'sd1 : $signed({4'b0, y[30:23]});
      p    = mx * my;
      if (xnan || ynan || (xinf && yz) || (xz && yinf)) begin
         r = rsnh_pkg::QNAN;
      end else if (xinf || yinf) begin
         r = {s, 8'hFF, 23'b0};
      end else if (xz || yz) begin
         r = {s, 31'b0};
      end else begin
         r = round_pack(s, ex + ey - 12'sd127, {p, 2'b00});
      end
      return r;
   endfunction

   // Sum of two binary32 values.
   function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
      logic               xnan;
      logic               ynan;
      logic               xinf;
      logic               yinf;
      logic [31:0]        big;
      logic [31:0]        sml;
      logic [7:0]         eb;
      logic [7:0]         es;
      logic [7:0]         d;
      logic [49:0]        bsig;
      logic [49:0]        ssig;
      logic [49:0]        ashift;
      logic               st;
      logic [49:0]        sum;
      logic               s;
      logic [31:0]        r;
      xnan = (x[30:23] == 8'hFF) && (x[22:0] != '0);
      ynan = (y[30:23] == 8'hFF) && (y[22:0] != '0);
      xinf = (x[30:23] == 8'hFF) && (x[22:0] == '0);
      yinf = (y[30:23] == 8'hFF) && (y[22:0] == '0);
      if (x[30:0] >= y[30:0]) begin
         big = x;
         sml = y;
      end else begin
         big = y;
         sml = x;
      end
      eb   = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
      es   = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
      d    = eb - es;
      bsig = {1'b0, big[30:23] != 8'h00, big[22:0], 25'b0};
      ssig = {1'b0, sml[30:23] != 8'h00, sml[22:0], 25'b0};
      // Align the smaller operand and fold lost bits into a sticky bit.
      if (d >= 8'd50) begin
         ashift = '0;
         st     = |ssig;
      end else begin
         ashift = ssig >> d;
         st     = |(ssig & ~({50{1'b1}} << d));
      end
      ashift[0] = ashift[0] | st;
      if (big[31] == sml[31]) begin
         sum = bsig + ashift;
      end else begin
         sum = bsig - ashift;
      end
      // An exact zero from opposite signs is positive zero.
      if (sum == '0) begin
         s = (big[31] == sml[31]) ? big[31] : 1'b0;
      end else begin
         s = big[31];
      end
      if (xnan || ynan || (xinf && yinf && (x[31] != y[31]))) begin
         r = rsnh_pkg::QNAN;
      end else if (xinf) begin
         r = x;
      end else if (yinf) begin
         r = y;
      end else begin
         r = round_pack(s, $signed({4'b0, eb}), sum);
      end
      return r;
   endfunction

   // Operation select.
   always_comb begin
      case (op)
         rsnh_pkg::FP_ADD: res_in = fp_add(a, b);
         rsnh_pkg::FP_SUB: res_in = fp_add(a, {~b[31], b[30:0]});
         rsnh_pkg::FP_MUL: res_in = fp_mul(a, b);
         default:          res_in = rsnh_pkg::QNAN;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

### hw/rtl/rsnh_sqrt.sv
// ----------------------------------------------------------------------------
// Ray-sphere nearest hit: binary32 square root
// Restoring integer square root, one result bit per cycle, followed by a
// round-to-nearest-even step.
// ----------------------------------------------------------------------------
module rsnh_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] arg,
   output logic        idle,
   output logic        done,
   output logic [31:0] result
);

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_RUN,
      SQ_ROUND,
      SQ_DONE
   } sq_state_type;

   localparam logic [4:0] LAST_STEP = 5'd25;

   sq_state_type       state_ff;
   logic [51:0]        n_ff;
   logic [25:0]        root_ff;
   logic [26:0]        rem_ff;
   logic signed [9:0]  half_ff;
   logic [4:0]         step_ff;
   logic [31:0]        res_ff;

   logic               is_special;
   logic [31:0]        special_res;
   logic [23:0]        m_norm;
   logic [4:0]         lz;
   logic               found;
   logic signed [9:0]  e_v;
   logic signed [9:0]  s_v;
   logic               odd;
   logic [24:0]        m_adj;
   logic signed [9:0]  half_v;
   logic [28:0]        rem_t;
   logic [28:0]        trial;
   logic               ge;
   logic [25:0]        q;
   logic               sticky;
   logic signed [9:0]  half_r;
   logic [23:0]        mant;
   logic [24:0]        m25;
   logic [9:0]         exp_r;
   logic [31:0]        round_res;

   // Operand setup: special values and normalized significand.
   always_comb begin
      lz    = '0;
      found = 1'b0;
      for (int i = 22; i >= 0; i--) begin
         if (!found && arg[i]) begin
            lz    = 5'(22 - i);
            found = 1'b1;
         end
      end
      if (arg[30:23] == 8'h00) begin
         m_norm = {1'b0, arg[22:0]} << (lz + 5'd1);
         e_v    = -10'sd126 - $signed({5'b0, lz}) - 10'sd1;
      end else begin
         m_norm = {1'b1, arg[22:0]};
         e_v    = $signed({2'b0, arg[30:23]}) - 10'sd127;
      end
      s_v    = e_v - 10'sd23;
      odd    = s_v[0];
      m_adj  = odd ? {m_norm, 1'b0} : {1'b0, m_norm};
      half_v = (s_v - $signed({9'b0, odd}) - 10'sd26) >>> 1;

      is_special  = 1'b1;
      if ((arg[30:23] == 8'hFF) && (arg[22:0] != '0)) begin
         special_res = arg | 32'h00400000;
      end else if (arg[30:0] == '0) begin
         special_res = arg;
      end else if (arg[31]) begin
         special_res = rsnh_pkg::QNAN;
      end else if (arg[30:23] == 8'hFF) begin
         special_res = arg;
      end else begin
         special_res = arg;
         is_special  = 1'b0;
      end
   end

   // One restoring root step.
   always_comb begin
      rem_t = {rem_ff, n_ff[51:50]};
      trial = {1'b0, root_ff, 2'b01};
      ge    = (rem_t >= trial);
   end

   // Final rounding of the integer root.
   always_comb begin
      q      = root_ff;
      sticky = (rem_ff != '0);
      half_r = half_ff;
      if (q[25]) begin
         sticky = sticky | q[0];
         q      = q >> 1;
         half_r = half_r + 10'sd1;
      end
      mant   = q[24:1];
      half_r = half_r + 10'sd1;
      m25    = {1'b0, mant} + 25'(q[0] & (sticky | mant[0]));
      if (m25[24]) begin
         mant   = m25[24:1];
         half_r = half_r + 10'sd1;
      end else begin
         mant = m25[23:0];
      end
      exp_r     = 10'(half_r + 10'sd150);
      round_res = {1'b0, exp_r[7:0], mant[22:0]};
   end

   // Sequencer and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            SQ_IDLE: begin
               if (start) begin
                  if (is_special) begin
                     res_ff   <= special_res;
                     state_ff <= SQ_DONE;
                  end else begin
                     n_ff     <= {1'b0, m_adj, 26'b0};
                     root_ff  <= '0;
                     rem_ff   <= '0;
                     half_ff  <= half_v;
                     step_ff  <= '0;
                     state_ff <= SQ_RUN;
                  end
               end
            end
            SQ_RUN: begin
               root_ff <= {root_ff[24:0], ge};
               rem_ff  <= ge ? 27'(rem_t - trial) : 27'(rem_t);
               n_ff    <= n_ff << 2;
               step_ff <= step_ff + 5'd1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= SQ_ROUND;
               end
            end
            SQ_ROUND: begin
               res_ff   <= round_res;
               state_ff <= SQ_DONE;
            end
            SQ_DONE: begin
               state_ff <= SQ_IDLE;
            end
            default: begin
               state_ff <= SQ_IDLE;
            end
         endcase
      end
   end

   assign idle   = (state_ff == SQ_IDLE);
   assign done   = (state_ff == SQ_DONE);
   assign result = res_ff;

endmodule

### hw/rtl/rsnh_front.sv
// ----------------------------------------------------------------------------
// Ray-sphere nearest hit: front end
// Accepts request beats, classifies them as sphere write, ray or no-op,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rsnh_front #(
   parameter int MAX_SPHERES = rsnh_pkg::MAX_SPHERES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  rsnh_pkg::req_type  req,
   output logic               item_valid,
   input  logic               item_take,
   output rsnh_pkg::item_type item
);

   rsnh_pkg::item_type ent_ff [2];
   logic               wr_ff;
   logic               rd_ff;
   logic [1:0]         cnt_ff;

   rsnh_pkg::item_type cls;
   logic               do_push;
   logic               do_pop;

   // Classify the incoming beat.
   always_comb begin
      cls.slot     = req.slot;
      cls.center_x = req.center_x;
      cls.center_y = req.center_y;
      cls.center_z = req.center_z;
      cls.radius   = req.radius;
      cls.origin_x = req.origin_x;
      cls.origin_y = req.origin_y;
      cls.origin_z = req.origin_z;
      cls.dir_x    = req.dir_x;
      cls.dir_y    = req.dir_y;
      cls.dir_z    = req.dir_z;
      if (req.cmd == rsnh_pkg::CMD_RAY) begin
         cls.kind = rsnh_pkg::KIND_RAY;
      end else if ({28'b0, req.slot} < 32'(MAX_SPHERES)) begin
         cls.kind = rsnh_pkg::KIND_WRITE;
      end else begin
         cls.kind = rsnh_pkg::KIND_NOP;
      end
   end

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = ent_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ff] <= cls;
      end
   end

   // Queue pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ff <= ~wr_ff;
         end
         if (do_pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= 2'(cnt_ff + {1'b0, do_push} - {1'b0, do_pop});
      end
   end

endmodule

### hw/rtl/rsnh_back.sv
// ----------------------------------------------------------------------------
// Ray-sphere nearest hit: back end
// Holds the sphere table, runs the geometric test for one sphere at a time
// on a shared float unit and square root, keeps the nearest hit and
// queues the result beats.
// ----------------------------------------------------------------------------
module rsnh_back #(
   parameter int MAX_SPHERES = rsnh_pkg::MAX_SPHERES_DEF,
   parameter int CW          = $clog2(MAX_SPHERES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_take,
   input  rsnh_pkg::item_type item,
   input  logic [CW-1:0]      count,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output rsnh_pkg::rsp_type  rsp
);

   localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

   typedef struct packed {
      logic [31:0] cx;
      logic [31:0] cy;
      logic [31:0] cz;
      logic [31:0] r2;
   } sphere_type;

   typedef enum logic [4:0] {
      S_IDLE, S_WMUL, S_WSTORE, S_RD, S_LX, S_LY, S_LZ, S_P1, S_P2, S_T1,
      S_P3, S_T2, S_CK1, S_L2, S_L3, S_L4, S_L5, S_L6, S_D2, S_CK2,
      S_SQ, S_SQW, S_T0, S_SEL, S_NEXT, S_DONE
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   rsnh_pkg::item_type item_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      cnt_ff;
   logic [31:0]        lx_ff;
   logic [31:0]        ly_ff;
   logic [31:0]        lz_ff;
   logic [31:0]        acc_ff;
   logic [31:0]        tca_ff;
   logic [31:0]        thc_ff;
   logic [31:0]        best_ff;
   logic [3:0]         best_slot_ff;
   logic               hit_ff;
   sphere_type         sphere_mem_ff [MAX_SPHERES];
   sphere_type         rd_ff;
   rsnh_pkg::rsp_type  q_ff [2];
   logic               q_wr_ff;
   logic               q_rd_ff;
   logic [1:0]         q_cnt_ff;

   rsnh_pkg::fp_op_type fp_op;
   logic [31:0]         fp_a;
   logic [31:0]         fp_b;
   logic [31:0]         fp_res;
   logic                mem_we;
   logic                mem_re;
   logic [AW-1:0]       mem_addr;
   logic                sq_start;
   logic                sq_idle;
   logic                sq_done;
   logic [31:0]         sq_res;
   logic                q_push;
   logic                q_pop;
   logic [31:0]         t_sel;

   // Binary32 less-than; NaN compares false and the two zeros are equal.
   function automatic logic fp_lt(input logic [31:0] x, input logic [31:0] y);
      logic r;
      if (((x[30:23] == 8'hFF) && (x[22:0] != '0)) ||
          ((y[30:23] == 8'hFF) && (y[22:0] != '0))) begin
         r = 1'b0;
      end else if ((x[30:0] == '0) && (y[30:0] == '0)) begin
         r = 1'b0;
      end else if (x[31] != y[31]) begin
         r = x[31];
      end else if (!x[31]) begin
         r = (x[30:0] < y[30:0]);
      end else begin
         r = (x[30:0] > y[30:0]);
      end
      return r;
   endfunction

   rsnh_fpu u_fpu (
      .clock (clock),
      .op    (fp_op),
      .a     (fp_a),
      .b     (fp_b),
      .res   (fp_res)
   );

   rsnh_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .arg    (fp_res),
      .idle   (sq_idle),
      .done   (sq_done),
      .result (sq_res)
   );

   // Candidate distance: near root, or far root when the near one is behind.
   assign t_sel = fp_lt(acc_ff, 32'h0) ? fp_res : acc_ff;

   // Sequencer control.
   always_comb begin
      state_in  = state_ff;
      fp_op     = rsnh_pkg::FP_ADD;
      fp_a      = acc_ff;
      fp_b      = fp_res;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = idx_ff[AW-1:0];
      sq_start  = 1'b0;
      item_take = 1'b0;
      q_push    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            item_take = item_valid;
            if (item_valid) begin
               case (item.kind)
                  rsnh_pkg::KIND_WRITE: state_in = S_WMUL;
                  rsnh_pkg::KIND_RAY:   state_in = (count == '0) ? S_DONE : S_RD;
                  default:              state_in = S_DONE;
               endcase
            end
         end
         S_WMUL: begin
            fp_op    = rsnh_pkg::FP_MUL;
            fp_a     = item_ff.radius;
            fp_b     = item_ff.radius;
            state_in = S_WSTORE;
         end
         S_WSTORE: begin
            mem_we   = 1'b1;
            mem_addr = AW'(item_ff.slot);
            state_in = S_DONE;
         end
         S_RD: begin
            mem_re   = 1'b1;
            state_in = S_LX;
         end
         S_LX: begin
            fp_op    = rsnh_pkg::FP_SUB;
            fp_a     = rd_ff.cx;
            fp_b     = item_ff.origin_x;
            state_in = S_LY;
         end
         S_LY: begin
            fp_op    = rsnh_pkg::FP_SUB;
            fp_a     = rd_ff.cy;
            fp_b     = item_ff.origin_y;
            state_in = S_LZ;
         end
         S_LZ: begin
            fp_op    = rsnh_pkg::FP_SUB;
            fp_a     = rd_ff.cz;
            fp_b     = item_ff.origin_z;
            state_in = S_P1;
         end
         S_P1: begin
            fp_op    = rsnh_pkg::FP_MUL;
            fp_a     = lx_ff;
            fp_b     = item_ff.dir_x;
            state_in = S_P2;
         end
         S_P2: begin
            fp_op    = rsnh_pkg::FP_MUL;
            fp_a     = ly_ff;
            fp_b     = item_ff.dir_y;
            state_in = S_T1;
         end
         S_T1: begin
            state_in = S_P3;
         end
         S_P3: begin
            fp_op    = rsnh_pkg::FP_MUL;
            fp_a     = lz_ff;
            fp_b     = item_ff.dir_z;
            state_in = S_T2;
         end
         S_T2: begin
            state_in = S_CK1;
         end
         S_CK1: begin
            fp_op    = rsnh_pkg::FP_MUL;
            fp_a     = lx_ff;
            fp_b     = lx_ff;
            state_in = fp_lt(fp_res, 32'h0) ? S_NEXT : S_L2;
         end
         S_L2: begin
            fp_op    = rsnh_pkg::FP_MUL;
            fp_a     = ly_ff;
            fp_b     = ly_ff;
            state_in = S_L3;
         end
         S_L3: begin
            state_in = S_L4;
         end
         S_L4: begin
            fp_op    = rsnh_pkg::FP_MUL;
            fp_a     = lz_ff;
            fp_b     = lz_ff;
            state_in = S_L5;
         end
         S_L5: begin
            state_in = S_L6;
         end
         S_L6: begin
            fp_op    = rsnh_pkg::FP_MUL;
            fp_a     = tca_ff;
            fp_b     = tca_ff;
            state_in = S_D2;
         end
         S_D2: begin
            fp_op    = rsnh_pkg::FP_SUB;
            state_in = S_CK2;
         end
         S_CK2: begin
            fp_op    = rsnh_pkg::FP_SUB;
            fp_a     = rd_ff.r2;
            fp_b     = fp_res;
            state_in = fp_lt(rd_ff.r2, fp_res) ? S_NEXT : S_SQ;
         end
         S_SQ: begin
            sq_start = 1'b1;
            state_in = S_SQW;
         end
         S_SQW: begin
            fp_op = rsnh_pkg::FP_SUB;
            fp_a  = tca_ff;
            fp_b  = sq_res;
            if (sq_done) begin
               state_in = S_T0;
            end
         end
         S_T0: begin
            fp_a     = tca_ff;
            fp_b     = thc_ff;
            state_in = S_SEL;
         end
         S_SEL: begin
            state_in = S_NEXT;
         end
         S_NEXT: begin
            state_in = (CW'(idx_ff + 1'b1) == cnt_ff) ? S_DONE : S_RD;
         end
         S_DONE: begin
            if (q_cnt_ff != 2'd2) begin
               q_push   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sphere table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sphere_mem_ff[mem_addr] <= {item_ff.center_x, item_ff.center_y,
                                     item_ff.center_z, fp_res};
      end
      if (mem_re) begin
         rd_ff <= sphere_mem_ff[mem_addr];
      end
   end

   // State and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  item_ff      <= item;
                  idx_ff       <= '0;
                  cnt_ff       <= count;
                  hit_ff       <= 1'b0;
                  best_slot_ff <= '0;
                  best_ff      <= (item.kind == rsnh_pkg::KIND_RAY) ?
                                  rsnh_pkg::MISS_DISTANCE : 32'h0;
               end
            end
            S_LY:   lx_ff  <= fp_res;
            S_LZ:   ly_ff  <= fp_res;
            S_P1:   lz_ff  <= fp_res;
            S_P2:   acc_ff <= fp_res;
            S_P3:   acc_ff <= fp_res;
            S_CK1:  tca_ff <= fp_res;
            S_L2:   acc_ff <= fp_res;
            S_L4:   acc_ff <= fp_res;
            S_L6:   acc_ff <= fp_res;
            S_SQW:  thc_ff <= sq_res;
            S_T0:   acc_ff <= fp_res;
            S_SEL: begin
               if (fp_lt(t_sel, best_ff)) begin
                  best_ff      <= t_sel;
                  best_slot_ff <= 4'(idx_ff);
                  hit_ff       <= 1'b1;
               end
            end
            S_NEXT: idx_ff <= CW'(idx_ff + 1'b1);
            default: begin
            end
         endcase
      end
   end

   // Result queue.
   assign q_pop     = rsp_pop && (q_cnt_ff != 2'd0);
   assign rsp_empty = (q_cnt_ff == 2'd0);
   assign rsp       = q_ff[q_rd_ff];

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[q_wr_ff] <= '{hit: hit_ff, hit_distance: best_ff,
                            hit_slot: (hit_ff ? best_slot_ff : 4'h0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= 1'b0;
         q_rd_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         if (q_push) begin
            q_wr_ff <= ~q_wr_ff;
         end
         if (q_pop) begin
            q_rd_ff <= ~q_rd_ff;
         end
         q_cnt_ff <= 2'(q_cnt_ff + {1'b0, q_push} - {1'b0, q_pop});
      end
   end

`ifndef SYNTHESIS
   // A table read always addresses a slot that takes part in the test.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (idx_ff < cnt_ff))
      else $error("sphere index beyond sphere count");

   // The square root is only started while it is free.
   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      sq_start |-> sq_idle)
      else $error("square root started while busy");

   // A result beat is never written into a full queue.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_cnt_ff != 2'd2))
      else $error("result queue overflow");

   // Each square root start is answered before the candidate is formed.
   a_sqrt_answer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T0) |-> $past(sq_done))
      else $error("candidate formed without a root");
`endif

endmodule

### hw/rtl/ray_sphere_nearest_hit.sv
// ----------------------------------------------------------------------------
// Ray-sphere nearest hit: top level
// A ray spends less time on a sphere behind its origin than on a candidate
// sphere, set by the shared float unit and the bit-per-cycle square root.
// One item is in the back end at a time; two more may wait on each side.
// Reset is synchronous; the sphere table is undefined until written.
// ----------------------------------------------------------------------------
module ray_sphere_nearest_hit #(
   parameter int MAX_SPHERES = rsnh_pkg::MAX_SPHERES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_center_x,
   input  logic [31:0] req_center_y,
   input  logic [31:0] req_center_z,
   input  logic [31:0] req_radius,
   input  logic [31:0] req_origin_x,
   input  logic [31:0] req_origin_y,
   input  logic [31:0] req_origin_z,
   input  logic [31:0] req_dir_x,
   input  logic [31:0] req_dir_y,
   input  logic [31:0] req_dir_z,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_hit,
   output logic [31:0] rsp_hit_distance,
   output logic [3:0]  rsp_hit_slot,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_sphere_count
);

   localparam int CW = $clog2(MAX_SPHERES + 1);

   logic [4:0]         sphere_count_ff;
   logic [CW-1:0]      count_eff;
   rsnh_pkg::req_type  req;
   rsnh_pkg::item_type item;
   logic               item_valid;
   logic               item_take;
   rsnh_pkg::rsp_type  rsp;

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sphere_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         sphere_count_ff <= csr_sphere_count;
      end
   end

   // The sphere count saturates at the table size.
   assign count_eff = ({27'b0, sphere_count_ff} > 32'(MAX_SPHERES)) ?
                      CW'(MAX_SPHERES) : CW'(sphere_count_ff);

   // Request beat.
   always_comb begin
      req.cmd      = req_cmd;
      req.slot     = req_slot;
      req.center_x = req_center_x;
      req.center_y = req_center_y;
      req.center_z = req_center_z;
      req.radius   = req_radius;
      req.origin_x = req_origin_x;
      req.origin_y = req_origin_y;
      req.origin_z = req_origin_z;
      req.dir_x    = req_dir_x;
      req.dir_y    = req_dir_y;
      req.dir_z    = req_dir_z;
   end

   rsnh_front #(
      .MAX_SPHERES (MAX_SPHERES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .req        (req),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   rsnh_back #(
      .MAX_SPHERES (MAX_SPHERES),
      .CW          (CW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .count      (count_eff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp)
   );

   assign rsp_hit          = rsp.hit;
   assign rsp_hit_distance = rsp.hit_distance;
   assign rsp_hit_slot     = rsp.hit_slot;

endmodule
